### design/rc5_pkg.sv
// rc5_pkg: shared types, constants and rotate helpers for the rc5 core
// depends on nothing; imported by every rc5 design file but rc5_ram

package rc5_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned IDX_W          = 5;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned ROUNDS_DEFAULT = 12;

  // request codes of an input word
  typedef enum logic [REQ_W-1:0] {
    REQ_KEY = 2'd0,
    REQ_ENC = 2'd1,
    REQ_DEC = 2'd2
  } rc5_req_e;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } rc5_state_e;

  // control for one step of the round unit
  typedef struct packed {
    logic decrypt;  // run the inverse round
    logic outer;    // key whitening step instead of a full round
  } rc5_step_t;

  function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] s);
    logic [2*WORD_W-1:0] t;
    t = {v, v} << s;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] v,
                                                  input logic [4:0] s);
    logic [2*WORD_W-1:0] t;
    t = {v, v} >> s;
    return t[WORD_W-1:0];
  endfunction

endpackage

### design/rc5_if.sv
// rc5_req_if and rc5_rsp_if: valid/ready channels of the rc5 core
// depends on rc5_pkg for field widths

interface rc5_req_if import rc5_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  key_index;
  logic [WORD_W-1:0] key_word;
  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] word_b;

  modport source (output valid, req_type, key_index, key_word, word_a, word_b,
                  input ready);
  modport sink   (input valid, req_type, key_index, key_word, word_a, word_b,
                  output ready);
endinterface

interface rc5_rsp_if import rc5_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_a;
  logic [WORD_W-1:0] result_b;

  modport source (output valid, result_a, result_b, input ready);
  modport sink   (input valid, result_a, result_b, output ready);
endinterface

### design/rc5_ram.sv
// rc5_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module rc5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rc5_key_store.sv
// rc5_key_store: key table split into even and odd word banks, one pair per read
// depends on rc5_pkg and rc5_ram

module rc5_key_store import rc5_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEFAULT,
  localparam int unsigned PW    = $clog2(ROUNDS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_index_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic [PW-1:0]     rd_pair_i,
  output logic [WORD_W-1:0] k_even_o,
  output logic [WORD_W-1:0] k_odd_o
);

  localparam int unsigned KEY_WORDS = 2 * ROUNDS + 2;
  // only indices below 2**IDX_W can ever be written; higher pairs read as zero
  localparam int unsigned MAX_PAIRS = (1 << IDX_W) / 2;
  localparam int unsigned PAIRS     = (ROUNDS + 1 < MAX_PAIRS) ? ROUNDS + 1 : MAX_PAIRS;
  localparam int unsigned AW        = $clog2(PAIRS);

  logic              wr_ok;
  logic              wr_even;
  logic              wr_odd;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_in_range;
  logic              ok_even_d, ok_even_q;
  logic              ok_odd_d, ok_odd_q;
  logic [PAIRS-1:0]  vld_even_q;
  logic [PAIRS-1:0]  vld_odd_q;
  logic [WORD_W-1:0] ram_even;
  logic [WORD_W-1:0] ram_odd;

  // write decode: bank by the low index bit, address by the rest
  assign wr_ok   = wr_en_i && (32'(wr_index_i) < KEY_WORDS);
  assign wr_even = wr_ok && !wr_index_i[0];
  assign wr_odd  = wr_ok && wr_index_i[0];
  assign wr_addr = wr_index_i[AW:1];

  assign rd_addr     = rd_pair_i[AW-1:0];
  assign rd_in_range = 32'(rd_pair_i) < PAIRS;

  rc5_ram #(.WIDTH(WORD_W), .DEPTH(PAIRS)) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (wr_even),
    .waddr_i (wr_addr),
    .wdata_i (wr_data_i),
    .raddr_i (rd_addr),
    .rdata_o (ram_even)
  );

  rc5_ram #(.WIDTH(WORD_W), .DEPTH(PAIRS)) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (wr_odd),
    .waddr_i (wr_addr),
    .wdata_i (wr_data_i),
    .raddr_i (rd_addr),
    .rdata_o (ram_odd)
  );

  // written flags: an entry never written since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_even_q <= '0;
      vld_odd_q  <= '0;
    end else begin
      if (wr_even) begin
        vld_even_q[wr_addr] <= 1'b1;
      end
      if (wr_odd) begin
        vld_odd_q[wr_addr] <= 1'b1;
      end
    end
  end

  // flags are registered alongside the registered ram read data, so they line up with it
  assign ok_even_d = rd_in_range && vld_even_q[rd_addr];
  assign ok_odd_d  = rd_in_range && vld_odd_q[rd_addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_even_q <= 1'b0;
      ok_odd_q  <= 1'b0;
    end else begin
      ok_even_q <= ok_even_d;
      ok_odd_q  <= ok_odd_d;
    end
  end

  assign k_even_o = ok_even_q ? ram_even : '0;
  assign k_odd_o  = ok_odd_q  ? ram_odd  : '0;

endmodule

### design/rc5_round_unit.sv
// rc5_round_unit: one rc5 round or key whitening step, forward or inverse
// depends on rc5_pkg

module rc5_round_unit import rc5_pkg::*; (
  input  rc5_step_t         step_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  input  logic [WORD_W-1:0] k_even_i,
  input  logic [WORD_W-1:0] k_odd_i,
  output logic [WORD_W-1:0] a_o,
  output logic [WORD_W-1:0] b_o
);

  logic [WORD_W-1:0] enc_a, enc_b;
  logic [WORD_W-1:0] dec_a, dec_b;

  // forward round: a first, then b with the new a
  assign enc_a = rot_left(a_i ^ b_i, b_i[4:0]) + k_even_i;
  assign enc_b = rot_left(b_i ^ enc_a, enc_a[4:0]) + k_odd_i;

  // inverse round: undo b first, then a with the new b
  assign dec_b = rot_right(b_i - k_odd_i, a_i[4:0]) ^ a_i;
  assign dec_a = rot_right(a_i - k_even_i, dec_b[4:0]) ^ dec_b;

  // step select
  always_comb begin
    case ({step_i.decrypt, step_i.outer})
      2'b01: begin
        a_o = a_i + k_even_i;
        b_o = b_i + k_odd_i;
      end
      2'b11: begin
        a_o = a_i - k_even_i;
        b_o = b_i - k_odd_i;
      end
      2'b10: begin
        a_o = dec_a;
        b_o = dec_b;
      end
      default: begin
        a_o = enc_a;
        b_o = enc_b;
      end
    endcase
  end

endmodule

### design/rc5_block_cipher_core.sv
// rc5_block_cipher_core: rc5-32 block cipher with a loaded key table
// a new block is taken only while idle, never while one is in work; one round per
// cycle through the round unit fed by one key pair read per cycle, the final step held
// while the previous result word waits, then back to idle.
// key-load words give no result.
// reset clears control state and the key written flags: the table reads zero.

module rc5_block_cipher_core import rc5_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEFAULT
) (
  input logic clk_i,
  input logic rst_ni,
  rc5_req_if.sink   req_i,
  rc5_rsp_if.source rsp_o
);

  localparam int unsigned PW = $clog2(ROUNDS + 1);

  rc5_state_e        state_q, state_d;
  logic [PW-1:0]     pair_q, pair_d;
  logic              dec_q, dec_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;
  logic              out_vld_q, out_vld_d;
  logic [WORD_W-1:0] res_a_q, res_b_q;

  logic              req_acc;
  logic              req_enc;
  logic              req_dec;
  logic              start;
  logic              key_wr;
  logic              busy;
  logic              last;
  logic              out_free;
  logic              finish;
  logic              advance;
  rc5_step_t         step;
  logic [WORD_W-1:0] k_even, k_odd;
  logic [WORD_W-1:0] rnd_a, rnd_b;

  // request decode
  assign req_acc = req_i.valid && req_i.ready;

  always_comb begin
    req_enc = 1'b0;
    req_dec = 1'b0;
    key_wr  = 1'b0;
    unique case (rc5_req_e'(req_i.req_type))
      REQ_KEY: key_wr  = req_acc;
      REQ_ENC: req_enc = 1'b1;
      REQ_DEC: req_dec = 1'b1;
      default: ;
    endcase
  end

  assign start = req_acc && (req_enc || req_dec);

  // progress of the current block
  assign busy     = (state_q == ST_BUSY);
  assign last     = dec_q ? (pair_q == '0) : (pair_q == PW'(ROUNDS));
  assign out_free = !out_vld_q || rsp_o.ready;
  assign finish   = busy && last && out_free;
  assign advance  = busy && !(last && !out_free);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_BUSY;
      ST_BUSY: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_BUSY: req_i.ready = 1'b0;
      default: req_i.ready = 1'b0;
    endcase
  end

  // key pair address: whitening pair first on encrypt, last round pair on decrypt;
  // a stalled final step reads the same pair again
  always_comb begin
    pair_d = pair_q;
    dec_d  = dec_q;
    if (!busy) begin
      if (start) begin
        dec_d  = req_dec;
        pair_d = req_dec ? PW'(ROUNDS) : '0;
      end
    end else if (advance) begin
      pair_d = dec_q ? pair_q - 1'b1 : pair_q + 1'b1;
    end
  end

  rc5_key_store #(.ROUNDS(ROUNDS)) u_keys (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (key_wr),
    .wr_index_i (req_i.key_index),
    .wr_data_i  (req_i.key_word),
    .rd_pair_i  (pair_d),
    .k_even_o   (k_even),
    .k_odd_o    (k_odd)
  );

  assign step.decrypt = dec_q;
  assign step.outer   = (pair_q == '0);

  rc5_round_unit u_round (
    .step_i   (step),
    .a_i      (a_q),
    .b_i      (b_q),
    .k_even_i (k_even),
    .k_odd_i  (k_odd),
    .a_o      (rnd_a),
    .b_o      (rnd_b)
  );

  // working block
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    if (!busy && start) begin
      a_d = req_i.word_a;
      b_d = req_i.word_b;
    end else if (advance) begin
      a_d = rnd_a;
      b_d = rnd_b;
    end
  end

  // result word
  always_comb begin
    out_vld_d = out_vld_q;
    if (finish) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pair_q    <= '0;
      dec_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pair_q    <= pair_d;
      dec_q     <= dec_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    if (finish) begin
      res_a_q <= rnd_a;
      res_b_q <= rnd_b;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.result_a = res_a_q;
  assign rsp_o.result_b = res_b_q;

endmodule

### design/rc5_core_checker.sv
// rc5_core_checker: port-level properties of the rc5 core, bound to its top
// depends on rc5_pkg and rc5_block_cipher_core

module rc5_core_checker import rc5_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic [REQ_W-1:0]  req_type_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [WORD_W-1:0] result_a_i,
  input logic [WORD_W-1:0] result_b_i
);

  // a waiting result word holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(result_a_i)
      && $stable(result_b_i))
    else $error("result word changed while stalled");

  // a block in work keeps the input side closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_type_i == REQ_ENC || req_type_i == REQ_DEC)
      |=> !req_ready_i)
    else $error("input taken while a block is in work");

  // key loads and unused codes never produce a result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_type_i != REQ_ENC && req_type_i != REQ_DEC
      && !rsp_valid_i |=> !rsp_valid_i)
    else $error("result word without a block");

  // no result word right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid_i)
    else $error("result word valid after reset");

endmodule

bind rc5_block_cipher_core rc5_core_checker u_rc5_core_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .result_a_i  (rsp_o.result_a),
  .result_b_i  (rsp_o.result_b)
);

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for rc5_block_cipher_core (rc5-32, 12 rounds)
// a scoreboard class predicts each block result from its own key table copy
// depends on rc5_pkg and the rc5_req_if / rc5_rsp_if interfaces
`timescale 1ns / 100ps

module tb_top;
  import rc5_pkg::*;

  localparam int unsigned KEY_WORDS    = 2 * ROUNDS_DEFAULT + 2;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;  // unused request code
  localparam int unsigned TARGET_WORDS = 950;
  localparam int unsigned MAX_GAP      = 13;
  localparam int unsigned DRAIN_CYCLES = 2 * (ROUNDS_DEFAULT + 1) + 4;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } rc5_block_t;

  // key table copy, cipher predictor and queue of pending blocks
  class rc5_cipher_board;
    logic [WORD_W-1:0] keys [KEY_WORDS];
    rc5_block_t        blocks_due [$];
    int unsigned       errors;

    function new();
      foreach (keys[i]) keys[i] = '0;
      errors = 0;
    endfunction

    function logic [WORD_W-1:0] rotl32(logic [WORD_W-1:0] v, logic [WORD_W-1:0] amt);
      int unsigned s;
      s = amt[4:0];
      if (s == 0) return v;
      return (v << s) | (v >> (WORD_W - s));
    endfunction

    function logic [WORD_W-1:0] rotr32(logic [WORD_W-1:0] v, logic [WORD_W-1:0] amt);
      int unsigned s;
      s = amt[4:0];
      if (s == 0) return v;
      return (v >> s) | (v << (WORD_W - s));
    endfunction

    function rc5_block_t encipher_block(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      rc5_block_t blk;
      blk.a = a + keys[0];
      blk.b = b + keys[1];
      for (int r = 1; r <= ROUNDS_DEFAULT; r++) begin
        blk.a = rotl32(blk.a ^ blk.b, blk.b) + keys[2*r];
        blk.b = rotl32(blk.b ^ blk.a, blk.a) + keys[2*r+1];
      end
      return blk;
    endfunction

    function rc5_block_t decipher_block(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      rc5_block_t blk;
      blk.a = a;
      blk.b = b;
      for (int r = ROUNDS_DEFAULT; r >= 1; r--) begin
        blk.b = rotr32(blk.b - keys[2*r+1], blk.a) ^ blk.a;
        blk.a = rotr32(blk.a - keys[2*r], blk.b) ^ blk.b;
      end
      blk.a = blk.a - keys[0];
      blk.b = blk.b - keys[1];
      return blk;
    endfunction

    // accepted request word: update the key table or queue a block result
    function void note_word(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                            logic [WORD_W-1:0] key, logic [WORD_W-1:0] a,
                            logic [WORD_W-1:0] b);
      case (kind)
        REQ_KEY: begin
          if (idx < KEY_WORDS) keys[idx] = key;
        end
        REQ_ENC: blocks_due.push_back(encipher_block(a, b));
        REQ_DEC: blocks_due.push_back(decipher_block(a, b));
        default: ;
      endcase
    endfunction

    // accepted result word: compare with the oldest pending block
    function void check_block(logic [WORD_W-1:0] res_a, logic [WORD_W-1:0] res_b);
      rc5_block_t want;
      if (blocks_due.size() == 0) begin
        $display("%0t: unexpected result word a=%h b=%h", $time, res_a, res_b);
        errors++;
        return;
      end
      want = blocks_due.pop_front();
      if (res_a !== want.a) begin
        $display("%0t: result_a expected %h actual %h", $time, want.a, res_a);
        errors++;
      end
      if (res_b !== want.b) begin
        $display("%0t: result_b expected %h actual %h", $time, want.b, res_b);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return blocks_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rc5_req_if req_if ();
  rc5_rsp_if rsp_if ();

  rc5_block_cipher_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  rc5_cipher_board board;
  bit              sender_steady;
  int unsigned     counted_words;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #600000;
    $display("tb: failure");
    $finish;
  end

  // input monitor
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      board.note_word(req_if.req_type, req_if.key_index, req_if.key_word,
                      req_if.word_a, req_if.word_b);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      board.check_block(rsp_if.result_a, rsp_if.result_b);
  end

  // result receiver with random stalls and stall-free stretches
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          taker_steady;
    rsp_if.ready = 1'b0;
    taken        = 0;
    taker_steady = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 40 == 0) taker_steady = ($urandom_range(0, 3) == 0);
      gap = taker_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  // one request word, held until accepted; called at a falling edge
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.req_type  = kind;
    req_if.key_index = idx;
    req_if.key_word  = key;
    req_if.word_a    = a;
    req_if.word_b    = b;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    counted_words++;
  endtask

  // hold the sender off until every pending block has come back
  task automatic drain_results();
    req_if.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // data values biased toward extremes, single bits and zero rotation amounts
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return $urandom & 32'hffff_ffe0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] spare_index();
    return IDX_W'($urandom_range(KEY_WORDS, 31));
  endfunction

  // stimulus
  initial begin
    rc5_block_t  ct;
    logic [WORD_W-1:0] pa, pb;
    int unsigned burst;
    int unsigned pick;

    board            = new();
    counted_words    = 0;
    sender_steady    = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_KEY;
    req_if.key_index = '0;
    req_if.key_word  = '0;
    req_if.word_a    = '0;
    req_if.word_b    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: cleared table, zero rotations, extremes, ignored words
    send_word(REQ_ENC, '1, '1, 32'h0, 32'h0);
    send_word(REQ_ENC, '0, '0, 32'hffff_ffff, 32'hffff_ffff);
    send_word(REQ_DEC, '1, '1, 32'h0, 32'hffff_ffff);
    send_word(REQ_NONE, '1, '1, 32'hffff_ffff, 32'hffff_ffff);
    send_word(REQ_KEY, 5'd0, 32'hffff_ffff, '1, '1);
    send_word(REQ_KEY, 5'd25, 32'h8000_0001, '0, '0);
    send_word(REQ_KEY, 5'd26, 32'h1234_5678, '1, '0);
    send_word(REQ_KEY, 5'd31, 32'hffff_ffff, '0, '1);
    send_word(REQ_KEY, 5'd1, 32'h0, '1, '1);
    send_word(REQ_ENC, 5'd31, 32'hffff_ffff, 32'h1, 32'h0);
    send_word(REQ_DEC, 5'd26, 32'h0, 32'hffff_ffff, 32'h0);
    send_word(REQ_ENC, '0, '0, 32'h20, 32'h40);
    send_word(REQ_NONE, '0, '0, 32'h0, 32'h0);
    drain_results();

    // directed: full random key table, then a round trip at the extremes
    for (int i = 0; i < KEY_WORDS; i++)
      send_word(REQ_KEY, IDX_W'(i), $urandom, pick_word(), pick_word());
    ct = board.encipher_block(32'hffff_ffff, 32'h0);
    send_word(REQ_ENC, '1, '1, 32'hffff_ffff, 32'h0);
    send_word(REQ_DEC, '0, '0, ct.a, ct.b);
    send_word(REQ_DEC, '1, '0, 32'h0, 32'h0);
    drain_results();

    // random phases: an occasional full key schedule followed by a burst of mixed request words
    while (counted_words < TARGET_WORDS) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < KEY_WORDS; i++)
          send_word(REQ_KEY, IDX_W'(i), pick_word(), pick_word(), pick_word());
      end
      burst = $urandom_range(8, 30);
      for (int n = 0; n < burst; n++) begin
        pick = $urandom_range(0, 99);
        pa   = pick_word();
        pb   = pick_word();
        if (pick < 30) begin
          send_word(REQ_ENC, IDX_W'($urandom), $urandom, pa, pb);
        end else if (pick < 55) begin
          send_word(REQ_DEC, IDX_W'($urandom), $urandom, pa, pb);
        end else if (pick < 75) begin
          // encrypt then decrypt the predicted ciphertext
          ct = board.encipher_block(pa, pb);
          send_word(REQ_ENC, IDX_W'($urandom), $urandom, pa, pb);
          send_word(REQ_DEC, IDX_W'($urandom), $urandom, ct.a, ct.b);
        end else if (pick < 85) begin
          send_word(REQ_KEY, IDX_W'($urandom_range(0, KEY_WORDS - 1)), pick_word(),
                    pa, pb);
        end else if (pick < 92) begin
          send_word(REQ_KEY, spare_index(), pick_word(), pa, pb);
        end else begin
          send_word(REQ_NONE, IDX_W'($urandom), $urandom, pa, pb);
        end
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    // wind down
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
design/rc5_pkg.sv
design/rc5_if.sv
design/rc5_ram.sv
design/rc5_key_store.sv
design/rc5_round_unit.sv
design/rc5_block_cipher_core.sv
design/rc5_core_checker.sv
tb/sv/tb_top.sv
